// ===== hdl/mact_pkg.sv =====
// ----------------------------------------------------------------------------
// Mutex approval count table package
// Shared sizes, defaults, field widths and codes of the approval count table.
// ----------------------------------------------------------------------------
package mact_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int CNT_W = 8;
    localparam int APP_W = 8;
    localparam int ACT_W = 2;
    localparam int EV_W  = 3;

    localparam logic [ACT_W-1:0] ACT_REQ    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPR   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REFUSE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

    localparam logic [EV_W-1:0] EV_GRANT   = 3'd0;
    localparam logic [EV_W-1:0] EV_QUEUED  = 3'd1;
    localparam logic [EV_W-1:0] EV_DUP     = 3'd2;
    localparam logic [EV_W-1:0] EV_COUNTED = 3'd3;
    localparam logic [EV_W-1:0] EV_NOTWAIT = 3'd4;
    localparam logic [EV_W-1:0] EV_REFUSED = 3'd5;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd6;
    localparam logic [EV_W-1:0] EV_NONE    = 3'd7;

endpackage

// ===== hdl/mutex_approval_count_table.sv =====
// ----------------------------------------------------------------------------
// Mutex approval count table
// Keeps local requesters that wait for a mutual-exclusion grant, counts down
// the approvals each one still needs, and refuses all of them on demand.
// ----------------------------------------------------------------------------
//  Channel  Signals                                             Direction
//  input    i_in_valid, o_in_stall, i_action, i_app_id         in
//  output   o_out_valid, i_out_stall, o_event_res,
//           o_result_app, o_approvals_left, o_last              out
//  config   i_cfg_valid, o_cfg_ready, i_cfg_data               in
//
// A sequencer scans the table slot by slot through the entry store's single
// read port (S_READ, then S_CHECK) and takes no new item until this one is done.
// Refuse-all emits one beat per waiting entry.
// Reset is synchronous and empties the table. A stalled output beat holds
// the scan in place until the beat is taken.
// ----------------------------------------------------------------------------
module mutex_approval_count_table #(
    parameter int TABLE_DEPTH = mact_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BITS     = mact_pkg::ID_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [mact_pkg::ACT_W-1:0] i_action,
    input  logic [mact_pkg::APP_W-1:0] i_app_id,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mact_pkg::EV_W-1:0]  o_event_res,
    output logic [mact_pkg::APP_W-1:0] o_result_app,
    output logic [mact_pkg::CNT_W-1:0] o_approvals_left,
    output logic                       o_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mact_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [mact_pkg::APP_W-1:0] IdMask = mact_pkg::APP_W'((1 << ID_BITS) - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [mact_pkg::CNT_W-1:0] r_num_part;
    logic [TABLE_DEPTH-1:0]     r_valid, n_valid;
    logic [mact_pkg::ACT_W-1:0] r_act;
    logic [ID_BITS-1:0]         r_app;
    logic [IW-1:0]              r_idx, n_idx;
    logic [IW-1:0]              r_free, n_free;
    logic                       r_free_ok, n_free_ok;

    logic                       r_out_valid;
    logic [mact_pkg::EV_W-1:0]  r_ev;
    logic [mact_pkg::APP_W-1:0] r_res_app;
    logic [mact_pkg::CNT_W-1:0] r_left;
    logic                       r_last;

    logic                       emit;
    logic [mact_pkg::EV_W-1:0]  e_ev;
    logic [mact_pkg::APP_W-1:0] e_app;
    logic [mact_pkg::CNT_W-1:0] e_left;
    logic                       e_last;

    logic                       we;
    logic [IW-1:0]              waddr;
    logic [mact_pkg::CNT_W-1:0] wcnt;
    logic [ID_BITS-1:0]         rd_app;
    logic [mact_pkg::CNT_W-1:0] rd_cnt;

    logic                       out_free;
    logic                       in_acc;
    logic                       hit;
    logic                       at_end;
    logic                       more_above;
    logic [mact_pkg::CNT_W-1:0] dec_cnt;
    logic [mact_pkg::APP_W-1:0] app_out;

    mact_entry_ram #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wapp (r_app),
        .i_wcnt (wcnt),
        .i_raddr(r_idx),
        .o_rapp (rd_app),
        .o_rcnt (rd_cnt)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign hit     = r_valid[r_idx] && (rd_app == r_app);
    assign at_end  = (r_idx == IW'(TABLE_DEPTH - 1));
    assign dec_cnt = rd_cnt - mact_pkg::CNT_W'(1);
    assign app_out = mact_pkg::APP_W'(r_app);

    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (r_valid[j] && (j > int'(r_idx))) begin
                more_above = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_idx     = r_idx;
        n_free    = r_free;
        n_free_ok = r_free_ok;
        emit      = 1'b0;
        e_ev      = mact_pkg::EV_GRANT;
        e_app     = app_out;
        e_left    = '0;
        e_last    = 1'b1;
        we        = 1'b0;
        waddr     = r_idx;
        wcnt      = dec_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_idx     = '0;
                n_free_ok = 1'b0;
                if (r_act == mact_pkg::ACT_REQ) begin
                    if (r_num_part <= mact_pkg::CNT_W'(1)) begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end else if (r_act == mact_pkg::ACT_APPR) begin
                    n_state = S_READ;
                end else if (r_act == mact_pkg::ACT_REFUSE) begin
                    if (r_valid == '0) begin
                        if (out_free) begin
                            emit    = 1'b1;
                            e_ev    = mact_pkg::EV_NONE;
                            e_app   = '0;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (out_free) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = at_end ? S_IDLE : S_READ;
                    if (r_act == mact_pkg::ACT_REFUSE) begin
                        if (r_valid[r_idx]) begin
                            emit           = 1'b1;
                            e_ev           = mact_pkg::EV_REFUSED;
                            e_app          = mact_pkg::APP_W'(rd_app);
                            e_left         = rd_cnt;
                            e_last         = !more_above;
                            n_valid[r_idx] = 1'b0;
                            if (!more_above) begin
                                n_state = S_IDLE;
                            end
                        end
                    end else if (r_act == mact_pkg::ACT_REQ) begin
                        if (!r_valid[r_idx] && !r_free_ok) begin
                            n_free    = r_idx;
                            n_free_ok = 1'b1;
                        end
                        if (hit) begin
                            emit    = 1'b1;
                            e_ev    = mact_pkg::EV_DUP;
                            e_left  = rd_cnt;
                            n_state = S_IDLE;
                        end else if (at_end) begin
                            emit = 1'b1;
                            if (n_free_ok) begin
                                we             = 1'b1;
                                waddr          = n_free;
                                wcnt           = r_num_part - mact_pkg::CNT_W'(1);
                                n_valid[n_free] = 1'b1;
                                e_ev           = mact_pkg::EV_QUEUED;
                                e_left         = wcnt;
                            end else begin
                                e_ev = mact_pkg::EV_FULL;
                            end
                        end
                    end else begin
                        if (hit) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (dec_cnt == '0) begin
                                n_valid[r_idx] = 1'b0;
                                e_ev           = mact_pkg::EV_GRANT;
                            end else begin
                                we     = 1'b1;
                                e_ev   = mact_pkg::EV_COUNTED;
                                e_left = dec_cnt;
                            end
                        end else if (at_end) begin
                            emit = 1'b1;
                            e_ev = mact_pkg::EV_NOTWAIT;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_num_part  <= mact_pkg::CNT_W'(1);
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_free      <= '0;
            r_free_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_idx     <= n_idx;
            r_free    <= n_free;
            r_free_ok <= n_free_ok;
            if (i_cfg_valid) begin
                r_num_part <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act <= i_action;
            r_app <= ID_BITS'(i_app_id & IdMask);
        end
        if (emit) begin
            r_ev      <= e_ev;
            r_res_app <= e_app;
            r_left    <= e_left;
            r_last    <= e_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_ev;
    assign o_result_app     = r_res_app;
    assign o_approvals_left = r_left;
    assign o_last           = r_last;

endmodule

// ===== hdl/mact_entry_ram.sv =====
// ----------------------------------------------------------------------------
// Entry store of the approval count table
// One write port and one registered read port holding the id and the
// remaining approval count of every table slot.
// ----------------------------------------------------------------------------
module mact_entry_ram #(
    parameter int TABLE_DEPTH = mact_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BITS     = mact_pkg::ID_BITS_DEF,
    localparam int IW         = $clog2(TABLE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [IW-1:0]              i_waddr,
    input  logic [ID_BITS-1:0]         i_wapp,
    input  logic [mact_pkg::CNT_W-1:0] i_wcnt,
    input  logic [IW-1:0]              i_raddr,
    output logic [ID_BITS-1:0]         o_rapp,
    output logic [mact_pkg::CNT_W-1:0] o_rcnt
);

    logic [ID_BITS-1:0]         r_app_mem [TABLE_DEPTH];
    logic [mact_pkg::CNT_W-1:0] r_cnt_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_app_mem[i_waddr] <= i_wapp;
            r_cnt_mem[i_waddr] <= i_wcnt;
        end
        o_rapp <= r_app_mem[i_raddr];
        o_rcnt <= r_cnt_mem[i_raddr];
    end

endmodule
